// ===== src/mmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared types and constants of the min/max column decimator.
// ----------------------------------------------------------------------------
package mmcd_pkg;

  localparam int MaxColumns = 4096;
  localparam int ColumnCapInt = (MaxColumns < 4096) ? MaxColumns : 4096;
  localparam logic [12:0] ColumnCap = 13'(ColumnCapInt);

  localparam int ColW = 12;
  localparam int RowW = 13;
  localparam int ValW = 16;
  localparam int CfgW = 32;
  localparam int CfgIdxW = 3;
  localparam int OutDataW = 40;
  localparam int InDataW = 48;

  localparam logic signed [RowW-1:0] RowLo = 13'sh1000;
  localparam logic signed [RowW-1:0] RowHi = 13'sh0fff;
  localparam logic signed [ValW-1:0] ValueMax = 16'sh7fff;
  localparam logic signed [ValW-1:0] ValueMin = 16'sh8000;

  localparam logic [31:0] ViewLengthRst = 32'd1;
  localparam logic [12:0] PlotWidthRst = 13'd1024;
  localparam logic [12:0] PlotHeightRst = 13'd512;
  localparam logic signed [ValW-1:0] ValueMinRst = 16'sh8000;
  localparam logic [31:0] RowScaleRst = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgViewLength = 3'd0,
    CfgPlotWidth  = 3'd1,
    CfgPlotHeight = 3'd2,
    CfgValueMin   = 3'd3,
    CfgRowScale   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DvIdle,
    DvCheck,
    DvIter
  } div_phase_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StCheck,
    StRowTop,
    StRowBot,
    StSend,
    StFinish
  } top_state_e;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [ColW-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic                   done;
    logic signed [RowW-1:0] row;
  } row_res_t;

  typedef struct packed {
    logic s_ready;
    logic div_start;
    logic row_start;
    logic row_use_low;
    logic cap_top;
    logic cap_bot;
    logic out_load;
  } ctl_t;

endpackage

// ===== src/mmcd_divider.sv =====
// ----------------------------------------------------------------------------
// mmcd_divider
// Column index: offset * width / length by restoring division, one quotient
// bit per cycle, with an early overflow check against length << 12.
// ----------------------------------------------------------------------------
module mmcd_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         offset_i,
  input  logic [12:0]         width_i,
  input  logic [31:0]         length_i,
  output mmcd_pkg::div_res_t  res_o
);

  mmcd_pkg::div_phase_e phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [44:0] rem_q, rem_d;
  logic [44:0] dsh_q, dsh_d;
  logic [11:0] quo_q, quo_d;
  logic        ovf_q, ovf_d;
  logic [31:0] len_ext;
  logic [44:0] lim;
  logic        ge;

  always_comb begin
    len_ext = (length_i == 32'd0) ? 32'd1 : length_i;
    lim     = {dsh_q[32:0], 12'b0};
    ge      = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    unique case (phase_q)
      mmcd_pkg::DvIdle: begin
        if (start_i) begin
          rem_d   = 45'(offset_i) * 45'(width_i);
          dsh_d   = {13'b0, len_ext};
          quo_d   = '0;
          ovf_d   = 1'b0;
          phase_d = mmcd_pkg::DvCheck;
        end
      end
      mmcd_pkg::DvCheck: begin
        ge = (rem_q >= lim);
        if (ge) begin
          ovf_d   = 1'b1;
          done_d  = 1'b1;
          phase_d = mmcd_pkg::DvIdle;
        end else begin
          dsh_d   = {dsh_q[33:0], 11'b0};
          cnt_d   = 4'd11;
          phase_d = mmcd_pkg::DvIter;
        end
      end
      mmcd_pkg::DvIter: begin
        ge    = (rem_q >= dsh_q);
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        quo_d = {quo_q[10:0], ge};
        dsh_d = {1'b0, dsh_q[44:1]};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          done_d  = 1'b1;
          phase_d = mmcd_pkg::DvIdle;
        end
      end
      default: phase_d = mmcd_pkg::DvIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mmcd_pkg::DvIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule

// ===== src/mmcd_row_unit.sv =====
// ----------------------------------------------------------------------------
// mmcd_row_unit
// Value to display row: offset from value_min, scale by 16.16 factor,
// subtract from the bottom row (height - 1), saturate. Three register stages.
// ----------------------------------------------------------------------------
module mmcd_row_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  value_i,
  input  logic signed [15:0]  vmin_i,
  input  logic [31:0]         scale_i,
  input  logic [12:0]         height_i,
  output mmcd_pkg::row_res_t  res_o
);

  logic               v1_q, v2_q, done_q;
  logic [16:0]        mag_q, mag_d;
  logic               neg1_q, neg1_d;
  logic [48:0]        prod_q, prod_d;
  logic               neg2_q;
  logic signed [12:0] row_q, row_d;
  logic signed [16:0] diff;
  logic signed [34:0] qs;
  logic signed [34:0] rowf;

  always_comb begin
    diff   = $signed({value_i[15], value_i}) - $signed({vmin_i[15], vmin_i});
    neg1_d = diff[16];
    mag_d  = diff[16] ? 17'(-diff) : 17'(diff);
    prod_d = 49'(mag_q) * 49'(scale_i);
    qs     = $signed({2'b00, prod_q[48:16]});
    if (neg2_q) begin
      qs = -qs;
    end
    rowf = $signed({22'b0, height_i}) - 35'sd1 - qs;
    if (rowf < 35'(mmcd_pkg::RowLo)) begin
      row_d = mmcd_pkg::RowLo;
    end else if (rowf > 35'(mmcd_pkg::RowHi)) begin
      row_d = mmcd_pkg::RowHi;
    end else begin
      row_d = rowf[12:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg1_q <= neg1_d;
    prod_q <= prod_d;
    neg2_q <= neg1_q;
    row_q  <= row_d;
  end

  assign res_o.done = done_q;
  assign res_o.row  = row_q;

endmodule

// ===== src/min_max_column_decimator.sv =====
// A sample's path: operand load, overflow check, 12 quotient bits, check, finish;
// s_axis_tready then rises again for the next transfer. A column at or past 4096
// exits the divider after the overflow check. Each bar adds two passes through
// the 3-stage row unit and a send, plus any output stall. A new sample is taken
// only once the last one is through and the block is back in idle.
// Reset: configuration returns to defaults, open column and neighbor clear at once.
// ----------------------------------------------------------------------------
// min_max_column_decimator
// Min/max peak-detect decimation of a trace into vertical display bars.
// ----------------------------------------------------------------------------
module min_max_column_decimator #(
  parameter int MaxColumns = mmcd_pkg::MaxColumns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[15:0], offset[47:16]
  input  logic        s_axis_tlast,   // final_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // bar_column, top_row, bottom_row, is_point
  output logic        m_axis_tlast    // last_bar
);

  localparam int ColumnCapInt = (MaxColumns < 4096) ? MaxColumns : 4096;
  localparam logic [12:0] ColumnCap = 13'(ColumnCapInt);

  mmcd_pkg::top_state_e state_q, state_d;
  mmcd_pkg::ctl_t       ctl;
  mmcd_pkg::div_res_t   div_res;
  mmcd_pkg::row_res_t   row_res;

  logic [31:0]        cfg_len_q;
  logic [12:0]        cfg_pw_q;
  logic [12:0]        cfg_ph_q;
  logic signed [15:0] cfg_vmin_q;
  logic [31:0]        cfg_rs_q;

  logic signed [15:0] value_q;
  logic               fin_q;
  logic [11:0]        col_q;
  logic               emit_last_q;
  logic signed [12:0] top_raw_q, bot_raw_q;

  logic [11:0]        open_col_q;
  logic               col_open_q;
  logic signed [15:0] col_low_q, col_high_q;
  logic [11:0]        prev_col_q;
  logic               prev_valid_q;
  logic signed [12:0] nbr_top_q, nbr_bot_q;

  logic               m_valid_q;
  logic               m_last_q;
  logic [11:0]        m_col_q;
  logic signed [12:0] m_top_q, m_bot_q;
  logic               m_point_q;

  logic [12:0]        pw_lim;
  logic               in_range;
  logic               need_emit;
  logic               out_free;
  logic               adj;
  logic signed [12:0] st_top, st_bot, sw_top, sw_bot;
  logic signed [15:0] row_value;

  mmcd_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctl.div_start),
    .offset_i (s_axis_tdata[47:16]),
    .width_i  (cfg_pw_q),
    .length_i (cfg_len_q),
    .res_o    (div_res)
  );

  assign row_value = ctl.row_use_low ? col_low_q : col_high_q;

  mmcd_row_unit u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctl.row_start),
    .value_i  (row_value),
    .vmin_i   (cfg_vmin_q),
    .scale_i  (cfg_rs_q),
    .height_i (cfg_ph_q),
    .res_o    (row_res)
  );

  always_comb begin
    pw_lim    = (cfg_pw_q > ColumnCap) ? ColumnCap : cfg_pw_q;
    in_range  = !div_res.ovf && ({1'b0, div_res.quo} < pw_lim);
    need_emit = in_range && col_open_q && (div_res.quo != open_col_q);
    out_free  = !m_valid_q || m_axis_tready;
  end

  // Stretch toward the left neighbor's unstretched bar, then order the rows.
  always_comb begin
    adj    = prev_valid_q && (({1'b0, prev_col_q} + 13'd1) == {1'b0, open_col_q});
    st_top = top_raw_q;
    st_bot = bot_raw_q;
    if (adj) begin
      if (bot_raw_q < nbr_top_q) begin
        st_bot = nbr_top_q;
      end else if (top_raw_q > nbr_bot_q) begin
        st_top = nbr_bot_q;
      end
    end
    if (st_top > st_bot) begin
      sw_top = st_bot;
      sw_bot = st_top;
    end else begin
      sw_top = st_top;
      sw_bot = st_bot;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmcd_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          state_d = mmcd_pkg::StDiv;
        end
      end
      mmcd_pkg::StDiv: begin
        if (div_res.done) begin
          state_d = mmcd_pkg::StCheck;
        end
      end
      mmcd_pkg::StCheck: begin
        state_d = need_emit ? mmcd_pkg::StRowTop : mmcd_pkg::StFinish;
      end
      mmcd_pkg::StRowTop: begin
        if (row_res.done) begin
          state_d = mmcd_pkg::StRowBot;
        end
      end
      mmcd_pkg::StRowBot: begin
        if (row_res.done) begin
          state_d = mmcd_pkg::StSend;
        end
      end
      mmcd_pkg::StSend: begin
        if (out_free) begin
          state_d = emit_last_q ? mmcd_pkg::StIdle : mmcd_pkg::StFinish;
        end
      end
      mmcd_pkg::StFinish: begin
        state_d = (fin_q && col_open_q) ? mmcd_pkg::StRowTop : mmcd_pkg::StIdle;
      end
      default: state_d = mmcd_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_q)
      mmcd_pkg::StIdle: begin
        ctl.s_ready   = 1'b1;
        ctl.div_start = s_axis_tvalid;
      end
      mmcd_pkg::StCheck:  ctl.row_start = need_emit;
      mmcd_pkg::StFinish: ctl.row_start = fin_q && col_open_q;
      mmcd_pkg::StRowTop: begin
        ctl.cap_top     = row_res.done;
        ctl.row_start   = row_res.done;
        ctl.row_use_low = 1'b1;
      end
      mmcd_pkg::StRowBot: ctl.cap_bot  = row_res.done;
      mmcd_pkg::StSend:   ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmcd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q  <= mmcd_pkg::ViewLengthRst;
      cfg_pw_q   <= mmcd_pkg::PlotWidthRst;
      cfg_ph_q   <= mmcd_pkg::PlotHeightRst;
      cfg_vmin_q <= mmcd_pkg::ValueMinRst;
      cfg_rs_q   <= mmcd_pkg::RowScaleRst;
    end else if (cfg_we_i) begin
      unique case (mmcd_pkg::cfg_idx_e'(cfg_index_i))
        mmcd_pkg::CfgViewLength: cfg_len_q  <= cfg_wdata_i;
        mmcd_pkg::CfgPlotWidth:  cfg_pw_q   <= cfg_wdata_i[12:0];
        mmcd_pkg::CfgPlotHeight: cfg_ph_q   <= cfg_wdata_i[12:0];
        mmcd_pkg::CfgValueMin:   cfg_vmin_q <= cfg_wdata_i[15:0];
        mmcd_pkg::CfgRowScale:   cfg_rs_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_col_q   <= '0;
      col_open_q   <= 1'b0;
      col_low_q    <= mmcd_pkg::ValueMax;
      col_high_q   <= mmcd_pkg::ValueMin;
      prev_col_q   <= '0;
      prev_valid_q <= 1'b0;
      nbr_top_q    <= '0;
      nbr_bot_q    <= '0;
      emit_last_q  <= 1'b0;
    end else begin
      if (state_q == mmcd_pkg::StCheck) begin
        emit_last_q <= 1'b0;
        if (in_range && !need_emit) begin
          if (!col_open_q) begin
            open_col_q <= div_res.quo;
            col_open_q <= 1'b1;
            col_low_q  <= value_q;
            col_high_q <= value_q;
          end else begin
            if (value_q < col_low_q) begin
              col_low_q <= value_q;
            end
            if (value_q > col_high_q) begin
              col_high_q <= value_q;
            end
          end
        end
      end
      if (state_q == mmcd_pkg::StFinish && fin_q) begin
        if (col_open_q) begin
          emit_last_q <= 1'b1;
        end else begin
          col_low_q    <= mmcd_pkg::ValueMax;
          col_high_q   <= mmcd_pkg::ValueMin;
          prev_valid_q <= 1'b0;
        end
      end
      if (ctl.out_load) begin
        nbr_top_q    <= top_raw_q;
        nbr_bot_q    <= bot_raw_q;
        prev_col_q   <= open_col_q;
        prev_valid_q <= 1'b1;
        if (emit_last_q) begin
          col_open_q   <= 1'b0;
          col_low_q    <= mmcd_pkg::ValueMax;
          col_high_q   <= mmcd_pkg::ValueMin;
          prev_valid_q <= 1'b0;
        end else begin
          open_col_q <= col_q;
          col_open_q <= 1'b1;
          col_low_q  <= value_q;
          col_high_q <= value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.div_start) begin
      value_q <= s_axis_tdata[15:0];
      fin_q   <= s_axis_tlast;
    end
    if (state_q == mmcd_pkg::StCheck) begin
      col_q <= div_res.quo;
    end
    if (ctl.cap_top) begin
      top_raw_q <= row_res.row;
    end
    if (ctl.cap_bot) begin
      bot_raw_q <= row_res.row;
    end
    if (ctl.out_load) begin
      m_col_q   <= open_col_q;
      m_top_q   <= sw_top;
      m_bot_q   <= sw_bot;
      m_point_q <= (sw_top == sw_bot);
      m_last_q  <= emit_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready = ctl.s_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {1'b0, m_point_q, m_bot_q, m_top_q, m_col_q};

`ifndef NO_ASSERTIONS
  a_rows_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_top_q <= m_bot_q))
    else $error("bar rows out of order");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.out_load && emit_last_q) |=> (!col_open_q && !prev_valid_q))
    else $error("final bar left column state behind");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == mmcd_pkg::StDiv))
    else $error("divider finished outside the divide state");
`endif

endmodule
